// ----- hw/rtl/dmvm_pkg.sv -----
// Shared types and constants for the dense matrix-vector multiply block.
package dmvm_pkg;

    localparam int DEFAULT_MAX_SIZE = 1024;

    localparam int SIZE_W  = 11;
    localparam int VAL_W   = 16;
    localparam int PROD_W  = 32;
    localparam int ACC_W   = 48;
    localparam int RES_W   = 32;
    localparam int ROW_W   = 10;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    localparam logic REG_SIZE_IN_USE = 1'b0;

    localparam logic CMD_VECTOR = 1'b0;
    localparam logic CMD_MATRIX = 1'b1;

    typedef struct packed {
        logic                    cmd;
        logic signed [VAL_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic signed [RES_W-1:0] row_result;
        logic [ROW_W-1:0]        row_index;
        logic                    last_row;
        logic                    saturated;
    } rsp_t;

    typedef struct packed {
        logic             load;
        logic             clr;
        logic             mac;
        logic             emit;
        logic             last;
        logic [ROW_W-1:0] row_index;
    } ctl_t;

endpackage

// ----- hw/rtl/dmvm_core.sv -----
// Vector store, multiply and accumulate pipeline, and result register.
module dmvm_core
    import dmvm_pkg::*;
#(
    parameter int MAX_SIZE = DEFAULT_MAX_SIZE,
    parameter int AW       = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    accept,
    input  ctl_t                    ctl,
    input  logic [AW-1:0]           addr,
    input  logic signed [VAL_W-1:0] value,
    output logic                    advance,
    output logic                    rsp_valid,
    input  logic                    rsp_stall,
    output rsp_t                    rsp_data
);

    logic [VAL_W-1:0] mem [MAX_SIZE];

    logic                     s1_valid_reg;
    ctl_t                     s1_ctl_reg;
    logic signed [VAL_W-1:0]  s1_value_reg;
    logic signed [VAL_W-1:0]  rd_reg;

    logic                     s2_valid_reg;
    ctl_t                     s2_ctl_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    logic [ACC_W-1:0]         acc_reg;
    logic [ACC_W-1:0]         acc_next;
    logic [ACC_W-1:0]         acc_base;
    logic [ACC_W-1:0]         sum;
    logic                     sat;
    logic signed [RES_W-1:0]  result;

    logic                     rsp_valid_reg;
    logic                     rsp_valid_next;
    rsp_t                     rsp_data_reg;

    assign advance = !rsp_valid_reg || !rsp_stall;

    always_ff @(posedge clk)
    begin
        if (accept && ctl.load)
        begin
            mem[addr] <= value;
        end
        if (accept && ctl.mac)
        begin
            rd_reg <= mem[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_ctl_reg   <= ctl;
            s1_value_reg <= value;
            s2_ctl_reg   <= s1_ctl_reg;
            prod_reg     <= prod_next;
        end
    end

    always_comb
    begin
        if (s1_ctl_reg.mac)
        begin
            prod_next = s1_value_reg * rd_reg;
        end
        else
        begin
            prod_next = '0;
        end
    end

    always_comb
    begin
        acc_base = s2_ctl_reg.clr ? '0 : acc_reg;
        sum      = acc_base + {{(ACC_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        sat      = !((&sum[ACC_W-1:RES_W-1]) || !(|sum[ACC_W-1:RES_W-1]));
        if (!sat)
        begin
            result = sum[RES_W-1:0];
        end
        else if (sum[ACC_W-1])
        begin
            result = {1'b1, {(RES_W - 1){1'b0}}};
        end
        else
        begin
            result = {1'b0, {(RES_W - 1){1'b1}}};
        end

        acc_next = acc_reg;
        if (advance && s2_valid_reg)
        begin
            acc_next = s2_ctl_reg.emit ? '0 : sum;
        end

        rsp_valid_next = rsp_valid_reg && rsp_stall;
        if (advance && s2_valid_reg && s2_ctl_reg.emit)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s2_valid_reg && s2_ctl_reg.emit)
        begin
            rsp_data_reg.row_result <= result;
            rsp_data_reg.row_index  <= s2_ctl_reg.row_index;
            rsp_data_reg.last_row   <= s2_ctl_reg.last;
            rsp_data_reg.saturated  <= sat;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule

// ----- hw/rtl/dense_matrix_vector_multiply_top.sv -----
// Top level of the dense matrix-vector multiply block with its register port.
// The block takes one request per clock cycle, vector loads and matrix elements alike,
// and holds its input only while a finished row result waits at the output and is
// stalled. Each matrix element passes a one-port vector memory read, a 16 by 16
// multiply and a 48-bit accumulate; a row's last element passes the read, product and
// result registers before its row result appears. The vector memory needs no clearing
// after reset, but every vector entry must be loaded before a matrix element reads it.
// The size register must be written only while no request is in flight.
module dense_matrix_vector_multiply_top
    import dmvm_pkg::*;
#(
    parameter int MAX_SIZE = DEFAULT_MAX_SIZE
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    input  logic              req_valid,
    output logic              req_stall,
    input  req_t              req_data,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output rsp_t              rsp_data
);

    localparam int AW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam logic [SIZE_W-1:0] SIZE_CAP =
        (MAX_SIZE >= (2 ** SIZE_W)) ? {SIZE_W{1'b1}} : SIZE_W'(MAX_SIZE);

    logic [SIZE_W-1:0] size_reg;
    logic [SIZE_W-1:0] load_idx_reg;
    logic [SIZE_W-1:0] load_idx_next;
    logic [SIZE_W-1:0] col_reg;
    logic [SIZE_W-1:0] col_next;
    logic [SIZE_W-1:0] row_reg;
    logic [SIZE_W-1:0] row_next;

    logic [SIZE_W-1:0] n_eff;
    logic [SIZE_W-1:0] idx;
    logic [SIZE_W-1:0] idx_inc;
    logic [SIZE_W-1:0] col_inc;
    logic [SIZE_W-1:0] row_inc;
    logic              advance;
    logic              accept;
    logic              cfg_write;
    ctl_t              ctl;
    logic [AW-1:0]     addr;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_SIZE_IN_USE)
        begin
            prdata = APB_DW'(size_reg);
        end
    end

    always_comb
    begin
        if (size_reg == '0)
        begin
            n_eff = SIZE_W'(1);
        end
        else if (size_reg > SIZE_CAP)
        begin
            n_eff = SIZE_CAP;
        end
        else
        begin
            n_eff = size_reg;
        end
    end

    assign accept    = req_valid && advance;
    assign req_stall = !advance;

    always_comb
    begin
        idx     = (load_idx_reg >= n_eff) ? '0 : load_idx_reg;
        idx_inc = idx + SIZE_W'(1);

        ctl           = '0;
        ctl.load      = (req_data.cmd == CMD_VECTOR);
        ctl.clr       = ctl.load && (idx == '0);
        ctl.mac       = (req_data.cmd == CMD_MATRIX) && (col_reg < n_eff);
        col_inc       = col_reg + SIZE_W'(ctl.mac);
        ctl.emit      = (req_data.cmd == CMD_MATRIX) && (col_inc >= n_eff);
        ctl.last      = (row_reg >= (n_eff - SIZE_W'(1)));
        ctl.row_index = row_reg[ROW_W-1:0];
        row_inc       = row_reg + SIZE_W'(1);

        addr = ctl.load ? AW'(idx) : AW'(col_reg);

        load_idx_next = load_idx_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        if (accept)
        begin
            if (ctl.load)
            begin
                load_idx_next = (idx_inc >= n_eff) ? '0 : idx_inc;
                if (ctl.clr)
                begin
                    col_next = '0;
                    row_next = '0;
                end
            end
            else if (ctl.emit)
            begin
                col_next = '0;
                row_next = (row_inc >= n_eff) ? '0 : row_inc;
            end
            else
            begin
                col_next = col_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg     <= SIZE_CAP;
            load_idx_reg <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
        end
        else
        begin
            if (cfg_write && (paddr[2] == REG_SIZE_IN_USE))
            begin
                size_reg <= pwdata[SIZE_W-1:0];
            end
            load_idx_reg <= load_idx_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
        end
    end

    dmvm_core #(
        .MAX_SIZE (MAX_SIZE),
        .AW       (AW)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .ctl       (ctl),
        .addr      (addr),
        .value     (req_data.value),
        .advance   (advance),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

endmodule
